[design/mrwt_pkg.sv]
// ----------------------------------------------------------------------------
// mrwt_pkg: shared types and constants for the Miller-Rabin witness test
// Operand width, verdict codes and the control bundle to the modular multiplier.
// ----------------------------------------------------------------------------
package mrwt_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    VERDICT_COMPOSITE = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_INVALID   = 2'd2
  } verdict_t;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
    word_t m;
  } mul_req_t;

endpackage

[design/miller_rabin_witness_test.sv]
// ----------------------------------------------------------------------------
// miller_rabin_witness_test: one Miller-Rabin round per word
// Checks the inputs, splits candidate-1, exponentiates and squares.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)        | tlast/tuser
//  s_axis  | in  | candidate[31:0], witness[63:32]  | none
//  m_axis  | out | verdict[1:0], zero-filled to 8   | none
//
//  Flow: one word at a time. Each modular product is computed in the
//  bit-serial multiplier; a round uses about 2*WIDTH products. An invalid
//  input has its verdict offered in the cycle after acceptance.
//  Reset: rst clears the sequencer and the output valid.
//  Stalls: the verdict holds in m_axis_tdata until taken; s_axis_tready
//  stays low from acceptance until the verdict is taken.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // candidate[31:0], witness[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // verdict[1:0], zeros above
);
  import mrwt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SPLIT = 7'b0000010,
    S_PMUL  = 7'b0000100,
    S_PSQR  = 7'b0001000,
    S_CHK   = 7'b0010000,
    S_SQR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     state;
  word_t      n, base, res, e;
  logic [CNT_W-1:0] s;
  verdict_t   verdict;
  mul_req_t   req;
  logic       mdone, wait_mul;
  word_t      prod, n_m1;

  assign n_m1 = n - word_t'(1);

  mrwt_mulmod u_mul (.clk(clk), .rst(rst), .req(req), .done(mdone), .prod(prod));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {6'd0, verdict};

  always_comb begin
    req = '{start: 1'b0, x: res, y: base, m: n};
    unique case (state)
      S_PMUL:  req = '{start: !wait_mul && e[0], x: res, y: base, m: n};
      S_PSQR:  req = '{start: !wait_mul, x: base, y: base, m: n};
      S_SQR:   req = '{start: !wait_mul, x: res, y: res, m: n};
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wait_mul <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          n    <= s_axis_tdata[WIDTH-1:0];
          base <= s_axis_tdata[32+WIDTH-1:32];
          // validate: odd, >=5, witness in 2..n-2
          if (!s_axis_tdata[0] || s_axis_tdata[WIDTH-1:0] < word_t'(5) ||
              s_axis_tdata[32+WIDTH-1:32] < word_t'(2) ||
              s_axis_tdata[32+WIDTH-1:32] > s_axis_tdata[WIDTH-1:0] - word_t'(2)) begin
            verdict <= VERDICT_INVALID;
            state   <= S_OUT;
          end else begin
            e     <= s_axis_tdata[WIDTH-1:0] - word_t'(1);
            s     <= '0;
            res   <= word_t'(1);
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          // strip one trailing zero per cycle
          if (!e[0]) begin
            e <= e >> 1;
            s <= s + CNT_W'(1);
          end else begin
            state <= e[0] ? S_PMUL : S_PSQR;
          end
        end
        S_PMUL: begin
          if (!e[0]) state <= S_PSQR;
          else if (!wait_mul) wait_mul <= 1'b1;
          else if (mdone) begin
            wait_mul <= 1'b0;
            res      <= prod;
            state    <= S_PSQR;
          end
        end
        S_PSQR: begin
          if (!wait_mul) wait_mul <= 1'b1;
          else if (mdone) begin
            wait_mul <= 1'b0;
            base     <= prod;
            e        <= e >> 1;
            state    <= ((e >> 1) == '0) ? S_CHK : S_PMUL;
          end
        end
        S_CHK: begin
          if (res == word_t'(1) || res == n_m1) begin
            verdict <= VERDICT_PRIME;
            state   <= S_OUT;
          end else if (s <= CNT_W'(1)) begin
            verdict <= VERDICT_COMPOSITE;
            state   <= S_OUT;
          end else begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (!wait_mul) wait_mul <= 1'b1;
          else if (mdone) begin
            wait_mul <= 1'b0;
            res      <= prod;
            s        <= s - CNT_W'(1);
            if (prod == n_m1) begin
              verdict <= VERDICT_PRIME;
              state   <= S_OUT;
            end else if (prod == word_t'(1) || s <= CNT_W'(2)) begin
              verdict <= VERDICT_COMPOSITE;
              state   <= S_OUT;
            end
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> verdict != 2'd3)
    else $error("bad verdict code");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SQR) |-> s >= CNT_W'(2))
    else $error("squaring past s-1");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !m_axis_tready) |=> $stable(verdict))
    else $error("verdict changed under stall");

endmodule

[design/mrwt_mulmod.sv]
// ----------------------------------------------------------------------------
// mrwt_mulmod: bit-serial modular multiplier
// Computes x*y mod m by add-and-double, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mrwt_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  mrwt_pkg::mul_req_t req,
  output logic              done,
  output mrwt_pkg::word_t   prod
);
  import mrwt_pkg::*;

  word_t x, y, m, acc;
  logic  busy;
  logic [WIDTH:0] acc_sum, dbl_sum;
  word_t acc_next, x_next;

  // modular add of values already below m
  always_comb begin
    acc_sum  = {1'b0, acc} + {1'b0, x};
    acc_next = (acc_sum >= {1'b0, m}) ? word_t'(acc_sum - {1'b0, m}) : acc_sum[WIDTH-1:0];
    dbl_sum  = {x, 1'b0};
    x_next   = (dbl_sum >= {1'b0, m}) ? word_t'(dbl_sum - {1'b0, m}) : dbl_sum[WIDTH-1:0];
  end

  // pulse done for one cycle once the multiplier bits run out
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (y == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      x    <= req.x;
      y    <= req.y;
      m    <= req.m;
      acc  <= '0;
    end else if (busy) begin
      if (y == '0) begin
        busy <= 1'b0;
      end else begin
        if (y[0]) acc <= acc_next;
        x <= x_next;
        y <= y >> 1;
      end
    end
  end

  assign prod = acc;

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> acc < m)
    else $error("accumulator not reduced");
  assert property (@(posedge clk) disable iff (rst) done |=> !done || $past(req.start, 2))
    else $error("done held");

endmodule
